@@ hdl/mexp_pkg.sv @@
// shared types and constants of the modular exponentiation pipeline
// no dependencies
package mexp_pkg;

  localparam int unsigned OPERAND_BITS = 32;
  localparam int unsigned MULT_STEPS   = OPERAND_BITS;
  localparam int unsigned EXP_ROWS     = OPERAND_BITS;
  localparam int unsigned OBUF_DEPTH   = 2;

  typedef logic [OPERAND_BITS-1:0] word_t;

  // one multiplier-bit cell: two interleaved modular products side by side
  typedef struct packed {
    logic  valid;
    word_t a_r;
    word_t a_s;
    word_t mult;
    word_t acc_r;
    word_t acc_s;
    word_t exp;
  } cell_t;

  // state between exponent rows
  typedef struct packed {
    logic  valid;
    word_t res;
    word_t sq;
    word_t exp;
  } stage_t;

endpackage

@@ hdl/mexp_cell.sv @@
// one bit step of two interleaved modular multiplications
// depends on mexp_pkg
module mexp_cell import mexp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  word_t modulus_i,
  input  cell_t cell_i,
  output cell_t cell_o
);

  // (2*acc + sel*a) mod m with acc, a below m
  function automatic word_t mod_step(word_t acc, word_t a, logic sel, word_t m);
    logic [OPERAND_BITS+1:0] t;
    logic [OPERAND_BITS+1:0] m1;
    logic [OPERAND_BITS+1:0] m2;
    logic [OPERAND_BITS+1:0] r;
    t  = ({2'b00, acc} << 1) + (sel ? {2'b00, a} : '0);
    m1 = {2'b00, m};
    m2 = {1'b0, m, 1'b0};
    if (t >= m2) begin
      r = t - m2;
    end else if (t >= m1) begin
      r = t - m1;
    end else begin
      r = t;
    end
    return r[OPERAND_BITS-1:0];
  endfunction

  logic  mbit;
  cell_t cell_d;
  cell_t cell_q;

  assign mbit = cell_i.mult[OPERAND_BITS-1];

  always_comb begin
    cell_d       = cell_i;
    cell_d.mult  = cell_i.mult << 1;
    cell_d.acc_r = mod_step(cell_i.acc_r, cell_i.a_r, mbit, modulus_i);
    cell_d.acc_s = mod_step(cell_i.acc_s, cell_i.a_s, mbit, modulus_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

@@ hdl/mexp_row.sv @@
// one exponent bit: a chain of cells forming res*sq and sq*sq mod m
// depends on mexp_pkg and mexp_cell
module mexp_row import mexp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  word_t  modulus_i,
  input  stage_t stage_i,
  output stage_t stage_o
);

  cell_t chain [MULT_STEPS+1];

  always_comb begin
    chain[0].valid = stage_i.valid;
    chain[0].a_r   = stage_i.res;
    chain[0].a_s   = stage_i.sq;
    chain[0].mult  = stage_i.sq;
    chain[0].acc_r = '0;
    chain[0].acc_s = '0;
    chain[0].exp   = stage_i.exp;
  end

  for (genvar k = 0; k < MULT_STEPS; k++) begin : g_cell
    mexp_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en_i),
      .modulus_i (modulus_i),
      .cell_i    (chain[k]),
      .cell_o    (chain[k+1])
    );
  end

  always_comb begin
    stage_o.valid = chain[MULT_STEPS].valid;
    stage_o.res   = chain[MULT_STEPS].exp[0] ? chain[MULT_STEPS].acc_r
                                             : chain[MULT_STEPS].a_r;
    stage_o.sq    = chain[MULT_STEPS].acc_s;
    stage_o.exp   = chain[MULT_STEPS].exp >> 1;
  end

endmodule

@@ hdl/modular_exponentiation.sv @@
// top level: base reduction, exponent rows and output buffer
// depends on mexp_pkg, mexp_cell and mexp_row
//
// Computes base^exponent mod modulus with right-to-left square-and-multiply
// over all 32 exponent bits. A new beat is taken every cycle while the output
// buffer is not full. A beat passes a chain of 32 cells that reduce the base,
// then 32 rows of 32 cells, one row per exponent bit and one cell per
// multiplier bit, then a two-entry output buffer that keeps the input open
// while one result waits. Write the modulus only while the block is empty.
// A modulus of zero gives 0, a modulus of one gives 0.
module modular_exponentiation import mexp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  modulus_we_i,
  input  word_t modulus_wdata_i,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  word_t base_i,
  input  word_t exponent_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output word_t power_mod_o
);

  word_t  modulus_q;
  word_t  one_mod;
  logic   en;
  cell_t  red   [MULT_STEPS+1];
  stage_t stage [EXP_ROWS+1];

  logic   push;
  logic   pop;
  word_t  obuf_q [OBUF_DEPTH];
  logic   wr_ptr_q, wr_ptr_d;
  logic   rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  word_t  result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= word_t'(2);
    end else if (modulus_we_i) begin
      modulus_q <= modulus_wdata_i;
    end
  end

  assign one_mod    = (modulus_q == word_t'(1)) ? '0 : word_t'(1);
  assign en         = (cnt_q != 2'(OBUF_DEPTH));
  assign in_ready_o = en;

  // base mod m by horner over the base bits
  always_comb begin
    red[0].valid = in_valid_i;
    red[0].a_r   = one_mod;
    red[0].a_s   = '0;
    red[0].mult  = base_i;
    red[0].acc_r = '0;
    red[0].acc_s = '0;
    red[0].exp   = exponent_i;
  end

  for (genvar k = 0; k < MULT_STEPS; k++) begin : g_red
    mexp_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .modulus_i (modulus_q),
      .cell_i    (red[k]),
      .cell_o    (red[k+1])
    );
  end

  always_comb begin
    stage[0].valid = red[MULT_STEPS].valid;
    stage[0].res   = red[MULT_STEPS].a_r;
    stage[0].sq    = red[MULT_STEPS].acc_r;
    stage[0].exp   = red[MULT_STEPS].exp;
  end

  for (genvar j = 0; j < EXP_ROWS; j++) begin : g_row
    mexp_row u_row (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .modulus_i (modulus_q),
      .stage_i   (stage[j]),
      .stage_o   (stage[j+1])
    );
  end

  // output buffer
  assign result = (modulus_q == '0) ? '0 : stage[EXP_ROWS].res;
  assign push   = en && stage[EXP_ROWS].valid;
  assign pop    = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      obuf_q[wr_ptr_q] <= result;
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign power_mod_o = obuf_q[rd_ptr_q];

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer count out of range");

  a_full_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'(OBUF_DEPTH) && pop) |=> in_ready_o)
    else $error("input stays blocked after a result beat left a full buffer");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> red[1].valid)
    else $error("accepted beat missing from first cell");

endmodule
